/* rtl/qpps_pkg.sv */
`timescale 1ns / 1ps
package qpps_pkg;

	localparam int unsigned IDX_W = 13;
	localparam int unsigned GEN_W = 31;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IN_DATA_W = 32;
	localparam int unsigned OUT_DATA_W = 32;

	localparam logic [1:0] CMD_BUILD = 2'd0;
	localparam logic [1:0] CMD_SWAP = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd5;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_FILL,
		OP_KRST,
		OP_MM,
		OP_ADD1,
		OP_ADD2,
		OP_RD_K,
		OP_RD_J,
		OP_WR_K,
		OP_WR_J,
		OP_INV_WR,
		OP_RD_U,
		OP_RD_V,
		OP_SW1,
		OP_SW2,
		OP_SW3,
		OP_SW4,
		OP_RD_OUT,
		OP_OUT,
		OP_ZERO
	} dp_op_t;

	typedef enum logic [2:0] {
		SEL_SEED,
		SEL_A,
		SEL_B,
		SEL_C,
		SEL_SQ,
		SEL_T,
		SEL_U,
		SEL_J
	} mm_sel_t;

	typedef struct packed {
		dp_op_t op;
		mm_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic bad;
		logic n_zero;
		logic k_end;
		logic mm_done;
	} dp_status_t;

endpackage

/* rtl/qpps_ram.sv */
`timescale 1ns / 1ps
module qpps_ram #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = 4097
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/qpps_mulmod.sv */
`timescale 1ns / 1ps
module qpps_mulmod (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] m,
	input logic [30:0] p,
	input logic [30:0] q,
	output logic done,
	output logic [30:0] result
);
	// Shift-and-add modular multiply, one multiplier bit per cycle, MSB first.
	// The operand p must already be below m.
	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [30:0] r_q;
	logic [30:0] p_q;
	logic [30:0] q_q;
	logic [31:0] m_q;
	logic [32:0] r2;
	logic [32:0] m1;
	logic [32:0] m2;
	logic [30:0] r_next;

	always_comb begin
		r2 = {1'b0, r_q, 1'b0} + (q_q[30] ? {2'b00, p_q} : 33'd0);
		m1 = {1'b0, m_q};
		m2 = {m_q, 1'b0};
		if (r2 >= m2) begin
			r_next = 31'(r2 - m2);
		end else if (r2 >= m1) begin
			r_next = 31'(r2 - m1);
		end else begin
			r_next = r2[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd30;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= 31'd0;
			p_q <= p;
			q_q <= q;
			m_q <= m;
		end else if (busy_q) begin
			r_q <= r_next;
			q_q <= {q_q[29:0], 1'b0};
		end
	end

	assign done = done_q;
	assign result = r_q;
endmodule

/* rtl/qpps_datapath.sv */
`timescale 1ns / 1ps
module qpps_datapath #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [qpps_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [qpps_pkg::GEN_W-1:0] cfg_data,
	input logic [qpps_pkg::IN_DATA_W-1:0] in_data,
	input qpps_pkg::dp_cmd_t cmd,
	output qpps_pkg::dp_status_t status,
	output logic [qpps_pkg::OUT_DATA_W-1:0] out_data
);
	import qpps_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH + 1);
	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

	logic [GEN_W-1:0] seed_q, coef_a_q, coef_b_q, coef_c_q, modulus_q;
	logic [IDX_W-1:0] count_q;

	logic [1:0] cmd_q;
	logic [IDX_W-1:0] u_q, v_q;
	logic [AW-1:0] k_q, j_q, f1_q, f2_q;
	logic [GEN_W-1:0] x_q, sa_q, sb_q, sc_q, sq_q, t_q, uu_q, acc_q;
	mm_sel_t dst_q;
	logic [IDX_W-1:0] res_val_q, res_pos_q;
	logic res_err_q;

	logic [IDX_W-1:0] n;
	logic u_ok, v_ok;
	logic [AW-1:0] ua, va;
	logic [31:0] gen_m;
	logic [30:0] one_m, one_k;

	logic mm_start, mm_done;
	logic [31:0] mm_m;
	logic [30:0] mm_p, mm_q, mm_res;

	logic [31:0] add_s;
	logic [30:0] add_r;

	logic fwd_we, inv_we;
	logic [AW-1:0] fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
	logic [AW-1:0] inv_waddr, inv_wdata, inv_rdata;

	always_comb begin
		n = ({19'd0, count_q} > DEPTH32) ? IDX_W'(TABLE_DEPTH) : count_q;
		u_ok = (u_q != '0) && (u_q <= n);
		v_ok = (v_q != '0) && (v_q <= n);
		ua = AW'(u_q);
		va = AW'(v_q);
		gen_m = (modulus_q == '0) ? 32'h8000_0000 : {1'b0, modulus_q};
		one_m = (modulus_q == 31'd1) ? 31'd0 : 31'd1;
		one_k = (k_q == AW'(1)) ? 31'd0 : 31'd1;
	end

	assign status.cmd = cmd_q;
	assign status.bad = (cmd_q == CMD_UNUSED) || ((cmd_q != CMD_BUILD) && !u_ok)
		|| ((cmd_q == CMD_SWAP) && !v_ok);
	assign status.n_zero = (n == '0);
	assign status.k_end = (32'(k_q) == 32'(n));
	assign status.mm_done = mm_done;

	// Operand selection for the shared modular multiplier.
	always_comb begin
		mm_start = (cmd.op == OP_MM);
		mm_m = gen_m;
		mm_p = one_m;
		mm_q = x_q;
		case (cmd.sel)
			SEL_SEED: mm_q = seed_q;
			SEL_A: mm_q = coef_a_q;
			SEL_B: mm_q = coef_b_q;
			SEL_C: mm_q = coef_c_q;
			SEL_SQ: mm_p = x_q;
			SEL_T: begin
				mm_p = sa_q;
				mm_q = sq_q;
			end
			SEL_U: mm_p = sb_q;
			SEL_J: begin
				mm_m = 32'(k_q);
				mm_p = one_k;
			end
			default: mm_q = x_q;
		endcase
	end

	qpps_mulmod u_mulmod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mm_start),
		.m(mm_m),
		.p(mm_p),
		.q(mm_q),
		.done(mm_done),
		.result(mm_res)
	);

	always_comb begin
		if (cmd.op == OP_ADD1) begin
			add_s = {1'b0, t_q} + {1'b0, uu_q};
		end else begin
			add_s = {1'b0, acc_q} + {1'b0, sc_q};
		end
		add_r = (add_s >= gen_m) ? 31'(add_s - gen_m) : add_s[30:0];
	end

	// Memory port steering.
	always_comb begin
		fwd_we = 1'b0;
		fwd_waddr = k_q;
		fwd_wdata = k_q;
		inv_we = 1'b0;
		inv_waddr = fwd_rdata;
		inv_wdata = k_q;
		case (cmd.op)
			OP_FILL: fwd_we = 1'b1;
			OP_WR_K: begin
				fwd_we = 1'b1;
				fwd_wdata = fwd_rdata;
			end
			OP_WR_J: begin
				fwd_we = 1'b1;
				fwd_waddr = j_q;
				fwd_wdata = f1_q;
			end
			OP_SW1: begin
				fwd_we = 1'b1;
				fwd_waddr = ua;
				fwd_wdata = fwd_rdata;
			end
			OP_SW2: begin
				fwd_we = 1'b1;
				fwd_waddr = va;
				fwd_wdata = f1_q;
			end
			OP_INV_WR: inv_we = 1'b1;
			OP_SW3: begin
				inv_we = 1'b1;
				inv_waddr = f2_q;
				inv_wdata = ua;
			end
			OP_SW4: begin
				inv_we = 1'b1;
				inv_waddr = f1_q;
				inv_wdata = va;
			end
			default: fwd_we = 1'b0;
		endcase
		case (cmd.op)
			OP_RD_J: fwd_raddr = j_q;
			OP_RD_U, OP_RD_OUT: fwd_raddr = ua;
			OP_RD_V: fwd_raddr = va;
			default: fwd_raddr = k_q;
		endcase
	end

	qpps_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH + 1)) u_fwd (
		.clk(clk),
		.we(fwd_we),
		.waddr(fwd_waddr),
		.wdata(fwd_wdata),
		.raddr(fwd_raddr),
		.rdata(fwd_rdata)
	);

	qpps_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH + 1)) u_inv (
		.clk(clk),
		.we(inv_we),
		.waddr(inv_waddr),
		.wdata(inv_wdata),
		.raddr(ua),
		.rdata(inv_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			modulus_q <= 31'd1;
			count_q <= 13'd1;
			x_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SEED: seed_q <= cfg_data;
					REG_COEF_A: coef_a_q <= cfg_data;
					REG_COEF_B: coef_b_q <= cfg_data;
					REG_COEF_C: coef_c_q <= cfg_data;
					REG_MODULUS: modulus_q <= cfg_data;
					REG_COUNT: count_q <= cfg_data[IDX_W-1:0];
					default: count_q <= count_q;
				endcase
			end
			if (mm_done && dst_q == SEL_SEED) begin
				x_q <= mm_res;
			end else if (cmd.op == OP_ADD2) begin
				x_q <= add_r;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			cmd_q <= in_data[1:0];
			u_q <= in_data[14:2];
			v_q <= in_data[27:15];
		end
		if (cmd.op == OP_LOAD || cmd.op == OP_KRST) begin
			k_q <= AW'(1);
		end else if (cmd.op == OP_FILL || cmd.op == OP_WR_J || cmd.op == OP_INV_WR) begin
			k_q <= k_q + AW'(1);
		end
		if (cmd.op == OP_MM) begin
			dst_q <= cmd.sel;
		end
		if (mm_done) begin
			case (dst_q)
				SEL_A: sa_q <= mm_res;
				SEL_B: sb_q <= mm_res;
				SEL_C: sc_q <= mm_res;
				SEL_SQ: sq_q <= mm_res;
				SEL_T: t_q <= mm_res;
				SEL_U: uu_q <= mm_res;
				SEL_J: j_q <= AW'(mm_res) + AW'(1);
				default: j_q <= j_q;
			endcase
		end
		if (cmd.op == OP_ADD1) begin
			acc_q <= add_r;
		end
		if (cmd.op == OP_RD_J || cmd.op == OP_RD_V) begin
			f1_q <= fwd_rdata;
		end
		if (cmd.op == OP_SW1) begin
			f2_q <= fwd_rdata;
		end
		if (cmd.op == OP_OUT) begin
			res_val_q <= IDX_W'(fwd_rdata);
			res_pos_q <= IDX_W'(inv_rdata);
			res_err_q <= 1'b0;
		end else if (cmd.op == OP_ZERO) begin
			res_val_q <= '0;
			res_pos_q <= '0;
			res_err_q <= status.bad;
		end
	end

	assign out_data = {5'd0, res_err_q, res_pos_q, res_val_q};
endmodule

/* rtl/qpps_ctrl.sv */
`timescale 1ns / 1ps
module qpps_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input qpps_pkg::dp_status_t status,
	output qpps_pkg::dp_cmd_t cmd
);
	import qpps_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_FILL, S_KRST, S_MM, S_MMW, S_ADD1, S_ADD2,
		S_RDK, S_RDJ, S_WRK, S_WRJ, S_IKRST, S_IRD, S_IWR,
		S_RDU, S_RDV, S_SW1, S_SW2, S_SW3, S_SW4, S_FIN, S_OUT, S_RES
	} state_t;

	state_t state_q;
	mm_sel_t sel_q;
	logic out_valid_q;
	logic out_free;
	logic out_set;

	assign out_free = !out_valid_q || out_ready;
	assign out_set = (state_q == S_OUT) || ((state_q == S_RES) && out_free);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.sel = sel_q;
		case (state_q)
			S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NOP;
			S_FILL: cmd.op = OP_FILL;
			S_KRST, S_IKRST: cmd.op = OP_KRST;
			S_MM: cmd.op = OP_MM;
			S_ADD1: cmd.op = OP_ADD1;
			S_ADD2: cmd.op = OP_ADD2;
			S_RDK, S_IRD: cmd.op = OP_RD_K;
			S_RDJ: cmd.op = OP_RD_J;
			S_WRK: cmd.op = OP_WR_K;
			S_WRJ: cmd.op = OP_WR_J;
			S_IWR: cmd.op = OP_INV_WR;
			S_RDU: cmd.op = OP_RD_U;
			S_RDV: cmd.op = OP_RD_V;
			S_SW1: cmd.op = OP_SW1;
			S_SW2: cmd.op = OP_SW2;
			S_SW3: cmd.op = OP_SW3;
			S_SW4: cmd.op = OP_SW4;
			S_FIN: cmd.op = out_free ? OP_RD_OUT : OP_NOP;
			S_OUT: cmd.op = OP_OUT;
			S_RES: cmd.op = out_free ? OP_ZERO : OP_NOP;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= SEL_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DEC;
				S_DEC: begin
					if (status.bad) begin
						state_q <= S_RES;
					end else if (status.cmd == CMD_BUILD) begin
						state_q <= status.n_zero ? S_RES : S_FILL;
					end else if (status.cmd == CMD_SWAP) begin
						state_q <= S_RDU;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FILL: if (status.k_end) state_q <= S_KRST;
				S_KRST: begin
					sel_q <= SEL_SEED;
					state_q <= S_MM;
				end
				S_MM: state_q <= S_MMW;
				S_MMW: begin
					if (status.mm_done) begin
						state_q <= S_MM;
						case (sel_q)
							SEL_SEED: sel_q <= SEL_A;
							SEL_A: sel_q <= SEL_B;
							SEL_B: sel_q <= SEL_C;
							SEL_C: sel_q <= SEL_SQ;
							SEL_SQ: sel_q <= SEL_T;
							SEL_T: sel_q <= SEL_U;
							SEL_U: state_q <= S_ADD1;
							SEL_J: state_q <= S_RDK;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD1: state_q <= S_ADD2;
				S_ADD2: begin
					sel_q <= SEL_J;
					state_q <= S_MM;
				end
				S_RDK: state_q <= S_RDJ;
				S_RDJ: state_q <= S_WRK;
				S_WRK: state_q <= S_WRJ;
				S_WRJ: begin
					if (status.k_end) begin
						state_q <= S_IKRST;
					end else begin
						sel_q <= SEL_SQ;
						state_q <= S_MM;
					end
				end
				S_IKRST: state_q <= S_IRD;
				S_IRD: state_q <= S_IWR;
				S_IWR: state_q <= status.k_end ? S_RES : S_IRD;
				S_RDU: state_q <= S_RDV;
				S_RDV: state_q <= S_SW1;
				S_SW1: state_q <= S_SW2;
				S_SW2: state_q <= S_SW3;
				S_SW3: state_q <= S_SW4;
				S_SW4: state_q <= S_FIN;
				S_FIN: if (out_free) state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				S_RES: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/quadratic_prng_permutation_shuffler_unit.sv */
`timescale 1ns / 1ps
// Channel     Direction  Handshake                       Payload
// s_axis      in         s_axis_tvalid / s_axis_tready   command beat
// m_axis      out        m_axis_tvalid / m_axis_tready   result beat
// cfg         in         cfg_we (no wait)                cfg_index, cfg_data
//
// One item is worked at a time; s_axis_tready is high only while the controller idles.
// A build fills the table, then each generator step runs four modular multiplies
// on the shared bit-serial multiplier plus adds and table accesses, and a final
// pass fills the inverse table.
// Reset is asynchronous and active low; the tables are not cleared and hold garbage
// until the first build. A stalled result beat holds in the output register while
// the next command beat is already accepted and worked.
module quadratic_prng_permutation_shuffler_unit #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata, from bit 0: cmd[1:0], first_index[14:2], second_index[27:15], zero pad
	input logic [qpps_pkg::IN_DATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdata, from bit 0: entry_value[12:0], value_position[25:13], error[26], zero pad
	output logic [qpps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic cfg_we,
	input logic [qpps_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [qpps_pkg::GEN_W-1:0] cfg_data
);
	import qpps_pkg::*;

	dp_cmd_t dp_cmd;
	dp_status_t dp_status;

	// The controller sequences the micro-operations; the datapath owns the tables and data registers.
	qpps_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.status(dp_status),
		.cmd(dp_cmd)
	);

	qpps_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(s_axis_tdata),
		.cmd(dp_cmd),
		.status(dp_status),
		.out_data(m_axis_tdata)
	);
endmodule

/* rtl/qpps_checker.sv */
`timescale 1ns / 1ps
module qpps_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command accepted while another is in work");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:27] == 5'd0)
		else $error("result padding not zero");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[25:0] == 26'd0)
		else $error("error result carries nonzero fields");
endmodule

bind quadratic_prng_permutation_shuffler_unit qpps_checker u_qpps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
	import qpps_pkg::*;

	localparam int unsigned DEPTH = 4096;
	// The stall limit must comfortably cover one full-size build of all 4096
	// entries.
	localparam int unsigned STALL_LIMIT = 2000000;
	localparam int unsigned RANDOM_ITEMS = 1700;

	typedef struct packed {
		logic [12:0] entry_value;
		logic [12:0] value_position;
		logic error;
	} shuffle_result_t;

	// Keeps its own copy of the permutation and the generator settings, and
	// holds the results that the block still owes.
	class shuffle_scoreboard;
		logic [30:0] seed, coef_a, coef_b, coef_c, modulus;
		logic [12:0] count;
		logic [12:0] fwd[0:DEPTH];
		logic [12:0] inv[0:DEPTH];
		logic [30:0] gen_value;
		shuffle_result_t owed[$];
		int unsigned mismatches;

		function new();
			seed = 0;
			coef_a = 0;
			coef_b = 0;
			coef_c = 0;
			modulus = 1;
			count = 1;
			gen_value = 0;
			mismatches = 0;
			for (int i = 0; i <= DEPTH; i++) begin
				fwd[i] = 0;
				inv[i] = 0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
			case (idx)
				REG_SEED: seed = val;
				REG_COEF_A: coef_a = val;
				REG_COEF_B: coef_b = val;
				REG_COEF_C: coef_c = val;
				REG_MODULUS: modulus = val;
				REG_COUNT: count = val[12:0];
				default: ;
			endcase
		endfunction

		function int unsigned used_count();
			return (count > DEPTH) ? DEPTH : count;
		endfunction

		// One step of the quadratic generator in exact modular arithmetic.
		// A zero modulus wraps at 2^31 instead.
		function logic [30:0] advance(logic [30:0] x);
			longint unsigned m, xr, sq, t, u, s;
			m = (modulus != 0) ? longint'(modulus) : (64'd1 << 31);
			xr = x % m;
			sq = (xr * xr) % m;
			t = ((coef_a % m) * sq) % m;
			u = ((coef_b % m) * xr) % m;
			s = (t + u + (coef_c % m)) % m;
			return s[30:0];
		endfunction

		function void shuffle();
			int unsigned n, j;
			logic [12:0] tmp;
			n = used_count();
			gen_value = seed;
			for (int unsigned i = 1; i <= n; i++)
				fwd[i] = i;
			for (int unsigned i = 1; i <= n; i++) begin
				gen_value = advance(gen_value);
				j = (gen_value % i) + 1;
				tmp = fwd[i];
				fwd[i] = fwd[j];
				fwd[j] = tmp;
			end
			for (int unsigned i = 1; i <= n; i++)
				inv[fwd[i]] = i;
		endfunction

		// Called for every accepted command beat.
		function void note(logic [1:0] cmd, logic [12:0] u, logic [12:0] v);
			shuffle_result_t r;
			int unsigned n;
			logic [12:0] fu, fv;
			n = used_count();
			r = '0;
			if (cmd == CMD_BUILD) begin
				shuffle();
			end else if (cmd == CMD_UNUSED || u == 0 || u > n ||
					(cmd == CMD_SWAP && (v == 0 || v > n))) begin
				r.error = 1'b1;
			end else begin
				if (cmd == CMD_SWAP) begin
					fu = fwd[u];
					fv = fwd[v];
					fwd[u] = fv;
					fwd[v] = fu;
					inv[fv] = u;
					inv[fu] = v;
				end
				r.entry_value = fwd[u];
				r.value_position = inv[u];
			end
			owed.push_back(r);
		endfunction

		// Called for every accepted result beat.
		function void check(logic [OUT_DATA_W-1:0] data);
			shuffle_result_t want, got;
			got.entry_value = data[12:0];
			got.value_position = data[25:13];
			got.error = data[26];
			if (owed.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, actual %h", $time, data);
				return;
			end
			want = owed.pop_front();
			if (got.entry_value !== want.entry_value) begin
				mismatches++;
				$display("%0t: entry_value expected %0d actual %0d", $time,
					want.entry_value, got.entry_value);
			end
			if (got.value_position !== want.value_position) begin
				mismatches++;
				$display("%0t: value_position expected %0d actual %0d", $time,
					want.value_position, got.value_position);
			end
			if (got.error !== want.error) begin
				mismatches++;
				$display("%0t: error expected %0b actual %0b", $time,
					want.error, got.error);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// tdata, from bit 0: cmd[1:0], first_index[14:2], second_index[27:15], zero pad
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// tdata, from bit 0: entry_value[12:0], value_position[25:13], error[26], zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GEN_W-1:0] cfg_data;

	shuffle_scoreboard sb;
	// Set near the end of the run so that the last beats go back to back.
	logic quiet;
	// Asks the result side for one long hold-off; it counts the stretch itself.
	logic hold_request;
	int unsigned stall_cycles;

	quadratic_prng_permutation_shuffler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side: random hold-off bursts, one long hold-off on request, and
	// a steady high ready once the run goes quiet.
	initial begin
		int unsigned burst;
		m_axis_tready = 1'b0;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				burst = 400;
			end else if (burst == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 6);
			end
			if (burst > 0) begin
				burst--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// Results are checked at the rising edge where the result beat is taken.
	// The same edge feeds the watchdog, which counts cycles without any beat or register write.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offers one command beat and returns after the edge that takes it.
	task automatic send_command(logic [1:0] cmd, logic [12:0] u, logic [12:0] v);
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {4'b0, v, u, cmd};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note(cmd, u, v);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		s_axis_tdata = $urandom;
	endtask

	// Waits until every owed result has arrived, so the block is idle.
	task automatic drain();
		while (sb.owed.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = $urandom;
	endtask

	task automatic set_generator(logic [30:0] s, logic [30:0] a, logic [30:0] b,
			logic [30:0] c, logic [30:0] m, logic [12:0] n);
		drain();
		write_reg(REG_SEED, s);
		write_reg(REG_COEF_A, a);
		write_reg(REG_COEF_B, b);
		write_reg(REG_COEF_C, c);
		write_reg(REG_MODULUS, m);
		write_reg(REG_COUNT, {18'b0, n});
	endtask

	// Swaps and lookups with random indices inside the built table, plus builds and errors.
	// Valid indices never exceed the count of the last build, so no unwritten
	// entry is ever read.
	task automatic random_item();
		int unsigned n, pick;
		logic [12:0] u, v;
		n = sb.used_count();
		pick = $urandom_range(0, 99);
		u = (n > 0) ? $urandom_range(1, n) : 13'd0;
		v = (n > 0) ? $urandom_range(1, n) : 13'd0;
		if (pick < 45) begin
			send_command(CMD_SWAP, u, v);
		end else if (pick < 80) begin
			send_command(CMD_LOOKUP, u, $urandom);
		end else if (pick < 83) begin
			send_command(CMD_BUILD, $urandom, $urandom);
		end else if (pick < 87) begin
			send_command(CMD_UNUSED, $urandom, $urandom);
		end else if (pick < 91) begin
			// Full-width indices, mostly beyond the count.
			send_command($urandom_range(1, 2), $urandom, $urandom);
		end else if (pick < 95) begin
			send_command(CMD_SWAP, u, (pick[0]) ? 13'd0 : 13'(n + 1));
		end else begin
			send_command(CMD_LOOKUP, (pick[0]) ? 13'd0 : 13'(n + 1), v);
		end
	endtask

	initial begin
		int unsigned sent;
		logic [30:0] m;
		bit long_hold_sent;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		long_hold_sent = 1'b0;
		stall_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: a small table, then every command and error kind.
		set_generator(31'd5, 31'd3, 31'd7, 31'd11, 31'd1000003, 13'd16);
		send_command(CMD_BUILD, 13'd0, 13'd0);
		send_command(CMD_LOOKUP, 13'd1, 13'h1fff);
		send_command(CMD_LOOKUP, 13'd16, 13'd0);
		send_command(CMD_SWAP, 13'd1, 13'd16);
		send_command(CMD_SWAP, 13'd7, 13'd7);
		send_command(CMD_LOOKUP, 13'd0, 13'd1);
		send_command(CMD_LOOKUP, 13'd17, 13'd1);
		send_command(CMD_SWAP, 13'h1fff, 13'd2);
		send_command(CMD_SWAP, 13'd3, 13'd0);
		send_command(CMD_SWAP, 13'd3, 13'd17);
		send_command(CMD_UNUSED, 13'd1, 13'd1);
		send_command(CMD_BUILD, 13'h1fff, 13'h1fff);
		send_command(CMD_LOOKUP, 13'd16, 13'd16);

		// Zero modulus wraps at 2^31; seed and coefficients at their maximum.
		set_generator(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'd0,
			13'd1);
		send_command(CMD_BUILD, 13'd0, 13'd0);
		send_command(CMD_SWAP, 13'd1, 13'd1);
		send_command(CMD_LOOKUP, 13'd1, 13'd0);
		send_command(CMD_LOOKUP, 13'd2, 13'd0);

		// A zero count empties the table, so every index is out of range.
		set_generator(31'd0, 31'd0, 31'd0, 31'd0, 31'h7fffffff, 13'd0);
		send_command(CMD_BUILD, 13'd0, 13'd0);
		send_command(CMD_LOOKUP, 13'd1, 13'd0);
		send_command(CMD_SWAP, 13'd1, 13'd1);

		// A count above the table depth is clipped to the depth: one full build.
		set_generator(31'd123456789, 31'd40000, 31'd2147483646, 31'd99, 31'd65521,
			13'h1fff);
		send_command(CMD_BUILD, 13'd0, 13'd0);
		send_command(CMD_LOOKUP, 13'd4096, 13'd0);
		send_command(CMD_SWAP, 13'd1, 13'd4096);
		send_command(CMD_LOOKUP, 13'd4097, 13'd0);

		// Random phases: fresh generator settings, a build, then mixed traffic.
		// Counts stay small since a build costs four modular multiplies per entry.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 4))
				0: m = 31'd0;
				1: m = $urandom_range(1, 20);
				default: m = $urandom;
			endcase
			set_generator($urandom, $urandom, $urandom, $urandom, m,
				($urandom_range(0, 7) == 0) ? 13'd1 : 13'($urandom_range(2, 40)));
			send_command(CMD_BUILD, $urandom, $urandom);
			sent++;
			repeat ($urandom_range(30, 80)) begin
				if (!long_hold_sent && sent >= RANDOM_ITEMS / 3) begin
					hold_request = 1'b1;
					long_hold_sent = 1'b1;
				end
				if (sent >= RANDOM_ITEMS - 150)
					quiet = 1'b1;
				random_item();
				sent++;
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
